// File: src/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [15:0] PROG_END = 16'hFFFF;
    localparam logic [11:0] OFF_MAX  = 12'hFFF;

    typedef enum logic [1:0] {
        KIND_NIT = 2'd0,
        KIND_PMT = 2'd1,
        KIND_ERR = 2'd2
    } result_kind_t;

    typedef struct packed {
        result_kind_t kind;
        logic [15:0]  prog_num;
        logic [12:0]  pid;
        logic [15:0]  stream_id;
        logic [4:0]   version;
        logic         current_next;
        logic [7:0]   section_index;
        logic [7:0]   last_section_index;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// File: src/psp_ifs.sv
`timescale 1ns / 1ps

interface psp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       section_start;

    modport source (output valid, section_byte, section_start, input ready);
    modport sink   (input valid, section_byte, section_start, output ready);
endinterface

interface psp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] prog_num;
    logic [12:0] pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;

    modport source (output valid, result_kind, prog_num, pid, stream_id, version,
                    current_next, section_index, last_section_index, input ready);
    modport sink   (input valid, result_kind, prog_num, pid, stream_id, version,
                    current_next, section_index, last_section_index, output ready);
endinterface

// File: src/psp_front.sv
`timescale 1ns / 1ps

module psp_front
    import psp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] section_byte,
    input  logic       section_start,
    output logic       push,
    output result_t    push_data
);

    logic [11:0] byte_offset_reg, byte_offset_next;
    logic [11:0] declared_length_reg, declared_length_next;
    logic        active_reg, active_next;
    logic        syntax_reg, syntax_next;
    logic [23:0] entry_reg, entry_next;
    logic [15:0] stream_id_reg, stream_id_next;
    logic [4:0]  version_reg, version_next;
    logic        current_next_reg, current_next_next;
    logic [15:0] sec_nums_reg, sec_nums_next;

    logic [11:0] off;
    logic [15:0] prog;

    always_comb
    begin
        byte_offset_next     = byte_offset_reg;
        declared_length_next = declared_length_reg;
        active_next          = active_reg;
        syntax_next          = syntax_reg;
        entry_next           = entry_reg;
        stream_id_next       = stream_id_reg;
        version_next         = version_reg;
        current_next_next    = current_next_reg;
        sec_nums_next        = sec_nums_reg;
        off                  = byte_offset_reg;
        prog                 = entry_reg[23:8];
        push                 = 1'b0;
        push_data.kind       = KIND_ERR;
        push_data.prog_num   = '0;
        push_data.pid        = '0;

        if (fire)
        begin
            if (section_start)
            begin
                active_next = 1'b1;
                off         = '0;
            end
            byte_offset_next = off;
            if (active_next)
            begin
                unique case (off)
                    12'd0: ;
                    12'd1:
                    begin
                        syntax_next          = section_byte[7];
                        declared_length_next = {section_byte[3:0], 8'h00};
                    end
                    12'd2: declared_length_next = {declared_length_reg[11:8], section_byte};
                    12'd3: stream_id_next = {section_byte, stream_id_reg[7:0]};
                    12'd4: stream_id_next = {stream_id_reg[15:8], section_byte};
                    12'd5:
                    begin
                        version_next      = section_byte[5:1];
                        current_next_next = section_byte[0];
                    end
                    12'd6: sec_nums_next = {section_byte, sec_nums_reg[7:0]};
                    12'd7:
                    begin
                        sec_nums_next = {sec_nums_reg[15:8], section_byte};
                        if (!syntax_reg)
                        begin
                            push           = 1'b1;
                            push_data.kind = KIND_ERR;
                            active_next    = 1'b0;
                        end
                        else if (declared_length_reg <= 12'd9)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // entry byte position is off - 8, modulo 4
                        unique case (off[1:0])
                            2'd0: entry_next = {section_byte, 16'h0000};
                            2'd1: entry_next = {entry_reg[23:16], section_byte, 8'h00};
                            2'd2: entry_next = {entry_reg[23:8], section_byte};
                            default:
                            begin
                                if (prog == PROG_END)
                                begin
                                    active_next = 1'b0;
                                end
                                else
                                begin
                                    push               = 1'b1;
                                    push_data.kind     = (prog == 16'h0000) ?
                                                         KIND_NIT : KIND_PMT;
                                    push_data.prog_num = prog;
                                    push_data.pid      = {entry_reg[4:0], section_byte};
                                    // next entry would start at off - 7
                                    if (({1'b0, off} + 13'd2) >= {1'b0, declared_length_reg})
                                        active_next = 1'b0;
                                end
                            end
                        endcase
                    end
                endcase

                if (active_next)
                begin
                    if (off == OFF_MAX)
                        active_next = 1'b0;
                    else
                        byte_offset_next = off + 12'd1;
                end
            end
        end

        push_data.stream_id          = stream_id_next;
        push_data.version            = version_next;
        push_data.current_next       = current_next_next;
        push_data.section_index      = sec_nums_next[15:8];
        push_data.last_section_index = sec_nums_next[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg     <= '0;
            declared_length_reg <= '0;
            active_reg          <= 1'b0;
            syntax_reg          <= 1'b0;
            stream_id_reg       <= '0;
            version_reg         <= '0;
            current_next_reg    <= 1'b0;
            sec_nums_reg        <= '0;
        end
        else
        begin
            byte_offset_reg     <= byte_offset_next;
            declared_length_reg <= declared_length_next;
            active_reg          <= active_next;
            syntax_reg          <= syntax_next;
            stream_id_reg       <= stream_id_next;
            version_reg         <= version_next;
            current_next_reg    <= current_next_next;
            sec_nums_reg        <= sec_nums_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: src/psp_fifo.sv
`timescale 1ns / 1ps

module psp_fifo
    import psp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_t      push_data,
    input  logic         pop,
    output result_t      pop_data,
    output fifo_status_t status
);

    result_t mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign status.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + FIFO_AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + FIFO_AW'(1);
        if (push && !pop)
            count_next = count_reg + (FIFO_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: src/psp_back.sv
`timescale 1ns / 1ps

module psp_back
    import psp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  result_t head_data,
    output logic    pop,
    psp_out_if.source out_ch
);

    logic    valid_reg;
    result_t data_reg;

    assign pop = head_valid && (!valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head_data;
    end

    assign out_ch.valid              = valid_reg;
    assign out_ch.result_kind        = data_reg.kind;
    assign out_ch.prog_num           = data_reg.prog_num;
    assign out_ch.pid                = data_reg.pid;
    assign out_ch.stream_id          = data_reg.stream_id;
    assign out_ch.version            = data_reg.version;
    assign out_ch.current_next       = data_reg.current_next;
    assign out_ch.section_index      = data_reg.section_index;
    assign out_ch.last_section_index = data_reg.last_section_index;

endmodule

// File: src/pat_section_parser.sv
`timescale 1ns / 1ps

// Program association table section parser.
// in_ch: one section byte per transfer; section_start marks the table id byte
//   and restarts parsing, dropping any section in progress.
// out_ch: one result per completed entry (network or program map PID), or one
//   syntax error result at header byte 7 when the syntax bit is clear. Each
//   result carries the header fields of its section. Entries with program
//   number 0xFFFF end the section silently.
// Throughput: one byte per cycle while the result queue is not full; the byte parsing itself never stalls.
// Output path: a result is written into the result queue by the transfer of the byte
//   that completes it, then moved into the output register and presented from there.
// Stall: results wait in a 4-entry queue plus the output register; in_ch.ready
//   drops only when the queue is full, and the output holds its payload
//   until taken.
// Reset: returns to idle; bytes are ignored until the next section_start. The
//   CRC is not checked.

module pat_section_parser
    import psp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    psp_in_if.sink    in_ch,
    psp_out_if.source out_ch
);

    logic         fire;
    logic         push;
    logic         pop;
    result_t      push_data;
    result_t      head_data;
    fifo_status_t fifo_st;

    assign in_ch.ready = !fifo_st.full;
    assign fire        = in_ch.valid && in_ch.ready;

    psp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .section_byte  (in_ch.section_byte),
        .section_start (in_ch.section_start),
        .push          (push),
        .push_data     (push_data)
    );

    psp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head_data),
        .status    (fifo_st)
    );

    psp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!fifo_st.empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// File: src/psp_checker.sv
`timescale 1ns / 1ps

module psp_checker
    import psp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [15:0] prog_num,
    input logic [12:0] pid
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(prog_num) && $stable(pid)
                                    && $stable(result_kind))
        else $error("result changed while stalled");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_ERR |-> prog_num == '0 && pid == '0)
        else $error("syntax error result carries entry fields");

    a_kind_prog: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == KIND_ERR)
                   || (result_kind == KIND_NIT && prog_num == '0)
                   || (result_kind == KIND_PMT && prog_num != '0
                       && prog_num != PROG_END))
        else $error("result kind does not match program number");

endmodule

bind pat_section_parser psp_checker u_psp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .result_kind (out_ch.result_kind),
    .prog_num    (out_ch.prog_num),
    .pid         (out_ch.pid)
);
